// ===== design/eln_pkg.sv =====
// Shared widths, register codes and helper functions of the epipolar line normalizer.
package eln_pkg;

  // Field and register widths
  localparam int unsigned PT_W      = 20;   // Q12.8 point coordinate
  localparam int unsigned COEF_W    = 21;   // Q3.18 matrix coefficient
  localparam int unsigned ROW_W     = 63;   // three packed coefficients
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned LA_W      = 16;   // Q1.15 line_a / line_b
  localparam int unsigned LC_W      = 24;   // Q16.8 line_c

  // Datapath widths
  localparam int unsigned PROD_W = COEF_W + PT_W;   // one exact product
  localparam int unsigned SUM_W  = PROD_W + 1;      // dot product, |v| < 2^41
  localparam int unsigned MAG_W  = SUM_W - 1;       // magnitude of a dot product
  localparam int unsigned H_W    = 6;               // index of the leading one
  localparam int unsigned NRM_TOP = 30;             // leading one after scaling
  localparam int unsigned NRM_W  = NRM_TOP + 1;     // scaled |a|, |b|
  localparam int unsigned SQ_W   = 2 * NRM_W;       // one square
  localparam int unsigned RT_W   = 64;              // root and remainder of the root
  localparam int unsigned SQRT_STEPS = 32;
  localparam int unsigned SQ_TOP = 62;              // weight of the first root step
  localparam int unsigned N_W    = 32;              // integer root
  localparam int unsigned DIV_W  = N_W + 1;         // divisor 2n
  localparam int unsigned QB     = 25;              // quotient bits kept
  localparam int unsigned SHL_W  = 47;              // largest numerator shift
  localparam int unsigned D_W    = MAG_W + SHL_W;   // shifted numerator
  localparam int unsigned SH_W   = 6;
  localparam int unsigned SH_AB  = 47;              // numerator shift for a, b: 47 - h
  localparam int unsigned SH_C   = 40;              // numerator shift for c: 40 - h
  localparam int unsigned FRONT_REGS = 7;
  localparam int unsigned PIPE_DEPTH = FRONT_REGS + (SQRT_STEPS + 1) + (QB + 1) + 1;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROW0 = 2'd0,
    CFG_ROW1 = 2'd1,
    CFG_ROW2 = 2'd2
  } cfg_idx_e;

  // Side data that travels with a point from stage 4 through the root stages
  typedef struct packed {
    logic [2:0][MAG_W-1:0] mag;
    logic [2:0]            neg;
    logic                  err;
    logic [H_W-1:0]        h;
  } carry_t;

  // Index of the top set bit, zero for a zero word
  function automatic logic [H_W-1:0] lead_one(logic [MAG_W-1:0] m);
    logic [H_W-1:0] h;
    h = '0;
    for (int i = 0; i < MAG_W; i++) begin
      if (m[i]) begin
        h = H_W'(i);
      end
    end
    return h;
  endfunction

  // Halve with round half up, apply sign and clamp to -lim .. lim - 1
  function automatic logic [QB-1:0] sat_round(logic [QB-1:0] q, logic sat, logic neg,
                                              logic [QB-1:0] lim);
    logic [QB:0]   q1;
    logic [QB-1:0] mag;
    q1  = {1'b0, q} + (QB+1)'(1);
    mag = q1[QB:1];
    if (neg) begin
      if (sat || mag > lim) begin
        mag = lim;
      end
      return QB'(~mag + QB'(1));
    end
    if (sat || mag > lim - QB'(1)) begin
      mag = lim - QB'(1);
    end
    return mag;
  endfunction

endpackage

// ===== design/eln_point_if.sv =====
// Point channel: valid/ready handshake with one homogeneous Q12.8 point.
interface eln_point_if
  import eln_pkg::*;
();
  logic                   valid;
  logic                   ready;
  logic signed [PT_W-1:0] point_x;
  logic signed [PT_W-1:0] point_y;
  logic signed [PT_W-1:0] point_w;

  modport source (output valid, point_x, point_y, point_w, input ready);
  modport sink   (input valid, point_x, point_y, point_w, output ready);
endinterface

// ===== design/eln_line_if.sv =====
// Line channel: valid/ready handshake with one normalized line and its error flag.
interface eln_line_if
  import eln_pkg::*;
();
  logic                   valid;
  logic                   ready;
  logic signed [LA_W-1:0] line_a;
  logic signed [LA_W-1:0] line_b;
  logic signed [LC_W-1:0] line_c;
  logic                   norm_error;

  modport source (output valid, line_a, line_b, line_c, norm_error, input ready);
  modport sink   (input valid, line_a, line_b, line_c, norm_error, output ready);
endinterface

// ===== design/epipolar_line_normalize.sv =====
// Epipolar line normalizer: point times 3x3 matrix, divided by the norm of (a, b).
//
// Usage: software writes the three matrix rows through the write port (cfg_we_i,
// cfg_idx_i, cfg_data_i) while no request is in flight. Each point request on
// point_i (x, y, w in Q12.8) yields exactly one line request on line_o: a and b in
// Q1.15, c in Q16.8, each rounded and saturated, and norm_error set with all
// coefficients zero when a and b are both zero.
// Throughput: one point per cycle while line_o is not stalled. The pipeline depth
// is set by the 32-step square-root chain and the 25-step restoring divider, one
// step per stage, plus the product, norm, divider setup and output stages.
// Reset clears the matrix rows to zero and empties the pipeline; the block is ready
// in the first cycle after reset.
// When the receiver stalls, the whole pipeline holds in place and the result stays
// on line_o; a one-entry input buffer takes the request already offered, so
// point_i.ready is a register and drops only while that buffer is full.
module epipolar_line_normalize
  import eln_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [ROW_W-1:0]     cfg_data_i,
  eln_point_if.sink            point_i,
  eln_line_if.source           line_o
);

  typedef struct packed {
    logic [RT_W-1:0] x;
    logic [RT_W-1:0] r;
    carry_t          cy;
  } sqs_t;

  typedef struct packed {
    logic [DIV_W-1:0] r;
    logic [QB-1:0]    lo;
    logic [QB-1:0]    q;
    logic             sat;
  } lane_t;

  typedef struct packed {
    lane_t [2:0]      ln;
    logic [DIV_W-1:0] d;
    logic [2:0]       neg;
    logic             err;
  } dvs_t;

  typedef struct packed {
    logic [LA_W-1:0] a;
    logic [LA_W-1:0] b;
    logic [LC_W-1:0] c;
    logic            err;
  } out_t;

  logic [ROW_W-1:0]      row_q [3];
  logic                  skid_vld_q, skid_vld_d;
  logic signed [PT_W-1:0] skid_pt_q [3];
  logic signed [PT_W-1:0] ent_pt [3];
  logic                  ent_vld;
  logic                  adv;
  logic [PIPE_DEPTH-1:0] vld_q;

  logic signed [PROD_W-1:0] prod_q [3][3];
  logic signed [PROD_W-1:0] prod_d [3][3];
  logic signed [SUM_W-1:0]  sum_q [3];
  logic [MAG_W-1:0]         mag3_q [3];
  logic [2:0]               neg3_q;
  carry_t                   c4_q, c5_q, c6_q, c7_q;
  logic [MAG_W-1:0]         m4_q;
  logic [NRM_W-1:0]         na_q, nb_q;
  logic [SQ_W-1:0]          sqa_q, sqb_q;
  sqs_t                     sq_q [SQRT_STEPS+1];
  dvs_t                     dv_q [QB+1];
  dvs_t                     prep_d;
  out_t                     out_q, out_d;

  // Write matrix rows
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q[0] <= '0;
      row_q[1] <= '0;
      row_q[2] <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ROW0: row_q[0] <= cfg_data_i;
        CFG_ROW1: row_q[1] <= cfg_data_i;
        CFG_ROW2: row_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Advance the pipeline unless a finished result is held
  assign adv           = !vld_q[PIPE_DEPTH-1] || line_o.ready;
  assign point_i.ready = !skid_vld_q;
  assign ent_vld       = skid_vld_q || point_i.valid;

  // Pick the buffered request ahead of the port
  always_comb begin
    if (skid_vld_q) begin
      ent_pt = skid_pt_q;
    end else begin
      ent_pt[0] = point_i.point_x;
      ent_pt[1] = point_i.point_y;
      ent_pt[2] = point_i.point_w;
    end
    if (skid_vld_q) begin
      skid_vld_d = !adv;
    end else begin
      skid_vld_d = point_i.valid && !adv;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_vld_q <= 1'b0;
    end else begin
      skid_vld_q <= skid_vld_d;
    end
  end

  // Hold the request that arrives during a stall
  always_ff @(posedge clk_i) begin
    if (!skid_vld_q && point_i.valid && !adv) begin
      skid_pt_q[0] <= point_i.point_x;
      skid_pt_q[1] <= point_i.point_y;
      skid_pt_q[2] <= point_i.point_w;
    end
  end

  // Valid bits move with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[PIPE_DEPTH-2:0], ent_vld};
    end
  end

  // Stage 1: nine exact products
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        prod_d[i][j] = $signed(row_q[i][COEF_W*j +: COEF_W]) * ent_pt[j];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      prod_q <= prod_d;
    end
  end

  // Stage 2: row sums
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        sum_q[i] <= {prod_q[i][0][PROD_W-1], prod_q[i][0]}
                  + {prod_q[i][1][PROD_W-1], prod_q[i][1]}
                  + {prod_q[i][2][PROD_W-1], prod_q[i][2]};
      end
    end
  end

  // Stage 3: sign and magnitude
  always_ff @(posedge clk_i) begin
    logic [SUM_W-1:0] abs_v;
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        abs_v     = sum_q[i][SUM_W-1] ? SUM_W'(-sum_q[i]) : SUM_W'(sum_q[i]);
        mag3_q[i] <= abs_v[MAG_W-1:0];
        neg3_q[i] <= sum_q[i][SUM_W-1];
      end
    end
  end

  // Stage 4: larger of |a| and |b|, zero norm check
  always_ff @(posedge clk_i) begin
    if (adv) begin
      c4_q.mag <= {mag3_q[2], mag3_q[1], mag3_q[0]};
      c4_q.neg <= neg3_q;
      c4_q.err <= (mag3_q[0] == '0) && (mag3_q[1] == '0);
      c4_q.h   <= '0;
      m4_q     <= (mag3_q[0] > mag3_q[1]) ? mag3_q[0] : mag3_q[1];
    end
  end

  // Stage 5: leading one
  always_ff @(posedge clk_i) begin
    carry_t nxt;
    if (adv) begin
      nxt   = c4_q;
      nxt.h = lead_one(m4_q);
      c5_q <= nxt;
    end
  end

  // Stage 6: scale |a| and |b| so the leading one sits at bit 30
  always_ff @(posedge clk_i) begin
    logic [MAG_W-1:0] ta, tb;
    if (adv) begin
      if (c5_q.h <= H_W'(NRM_TOP)) begin
        ta = c5_q.mag[0] << (H_W'(NRM_TOP) - c5_q.h);
        tb = c5_q.mag[1] << (H_W'(NRM_TOP) - c5_q.h);
      end else begin
        ta = c5_q.mag[0] >> (c5_q.h - H_W'(NRM_TOP));
        tb = c5_q.mag[1] >> (c5_q.h - H_W'(NRM_TOP));
      end
      na_q <= ta[NRM_W-1:0];
      nb_q <= tb[NRM_W-1:0];
      c6_q <= c5_q;
    end
  end

  // Stage 7: squares
  always_ff @(posedge clk_i) begin
    if (adv) begin
      sqa_q <= na_q * na_q;
      sqb_q <= nb_q * nb_q;
      c7_q  <= c6_q;
    end
  end

  // Stage 8: sum of squares, start of the root chain
  always_ff @(posedge clk_i) begin
    if (adv) begin
      sq_q[0].x  <= RT_W'(sqa_q) + RT_W'(sqb_q);
      sq_q[0].r  <= '0;
      sq_q[0].cy <= c7_q;
    end
  end

  // Square root, one result bit per stage
  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    localparam logic [RT_W-1:0] STEP_BIT = RT_W'(1) << (SQ_TOP - 2 * k);
    sqs_t            step_d;
    logic [RT_W-1:0] trial;

    always_comb begin
      step_d = sq_q[k];
      trial  = sq_q[k].r + STEP_BIT;
      if (sq_q[k].x >= trial) begin
        step_d.x = sq_q[k].x - trial;
        step_d.r = (sq_q[k].r >> 1) + STEP_BIT;
      end else begin
        step_d.r = sq_q[k].r >> 1;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        sq_q[k+1] <= step_d;
      end
    end
  end

  // Divider setup: shifted numerators, overflow check, first remainders
  always_comb begin
    logic [DIV_W-1:0] d;
    logic [SH_W-1:0]  sh;
    logic [D_W-1:0]   wide;
    d = {sq_q[SQRT_STEPS].r[N_W-1:0], 1'b0};
    prep_d.d   = d;
    prep_d.neg = sq_q[SQRT_STEPS].cy.neg;
    prep_d.err = sq_q[SQRT_STEPS].cy.err;
    for (int i = 0; i < 3; i++) begin
      sh = (i < 2) ? SH_W'(SH_AB) - sq_q[SQRT_STEPS].cy.h
                   : SH_W'(SH_C) - sq_q[SQRT_STEPS].cy.h;
      wide = {{(D_W-MAG_W){1'b0}}, sq_q[SQRT_STEPS].cy.mag[i]} << sh;
      prep_d.ln[i].sat = (|wide[D_W-1:QB+DIV_W]) || (wide[QB+DIV_W-1:QB] >= d);
      prep_d.ln[i].r   = wide[QB+DIV_W-1:QB];
      prep_d.ln[i].lo  = wide[QB-1:0];
      prep_d.ln[i].q   = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dv_q[0] <= prep_d;
    end
  end

  // Restoring division, one quotient bit per stage for all three lanes
  for (genvar j = 0; j < QB; j++) begin : g_div
    dvs_t step_d;

    always_comb begin
      logic [DIV_W:0] rr;
      logic           qb;
      step_d = dv_q[j];
      for (int i = 0; i < 3; i++) begin
        rr = {dv_q[j].ln[i].r, dv_q[j].ln[i].lo[QB-1]};
        qb = rr >= {1'b0, dv_q[j].d};
        if (qb) begin
          rr = rr - {1'b0, dv_q[j].d};
        end
        step_d.ln[i].r  = rr[DIV_W-1:0];
        step_d.ln[i].lo = {dv_q[j].ln[i].lo[QB-2:0], 1'b0};
        step_d.ln[i].q  = {dv_q[j].ln[i].q[QB-2:0], qb};
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        dv_q[j+1] <= step_d;
      end
    end
  end

  // Round, sign and saturate into the output fields
  always_comb begin
    logic [QB-1:0] ra, rb, rc;
    ra = sat_round(dv_q[QB].ln[0].q, dv_q[QB].ln[0].sat, dv_q[QB].neg[0],
                   QB'(1) << (LA_W - 1));
    rb = sat_round(dv_q[QB].ln[1].q, dv_q[QB].ln[1].sat, dv_q[QB].neg[1],
                   QB'(1) << (LA_W - 1));
    rc = sat_round(dv_q[QB].ln[2].q, dv_q[QB].ln[2].sat, dv_q[QB].neg[2],
                   QB'(1) << (LC_W - 1));
    out_d.err = dv_q[QB].err;
    out_d.a   = dv_q[QB].err ? '0 : ra[LA_W-1:0];
    out_d.b   = dv_q[QB].err ? '0 : rb[LA_W-1:0];
    out_d.c   = dv_q[QB].err ? '0 : rc[LC_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= out_d;
    end
  end

  assign line_o.valid      = vld_q[PIPE_DEPTH-1];
  assign line_o.line_a     = $signed(out_q.a);
  assign line_o.line_b     = $signed(out_q.b);
  assign line_o.line_c     = $signed(out_q.c);
  assign line_o.norm_error = out_q.err;

endmodule

// ===== design/eln_checker.sv =====
// Port-level checks of the epipolar line normalizer and their binding.
module eln_checker
  import eln_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_valid_i,
  input logic                   in_ready_i,
  input logic                   out_valid_i,
  input logic                   out_ready_i,
  input logic signed [LA_W-1:0] line_a_i,
  input logic signed [LA_W-1:0] line_b_i,
  input logic signed [LC_W-1:0] line_c_i,
  input logic                   norm_error_i
);

  // A stalled result holds its place and value
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(line_a_i) && $stable(line_b_i)
      && $stable(line_c_i) && $stable(norm_error_i))
    else $error("stalled line request changed");

  // A zero norm gives an all-zero line
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && norm_error_i |-> line_a_i == '0 && line_b_i == '0 && line_c_i == '0)
    else $error("norm error with nonzero coefficients");

  // A normalized line never has a and b both zero
  a_unit_norm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !norm_error_i |-> line_a_i != '0 || line_b_i != '0)
    else $error("normalized line with zero a and b");

  // Ready drops only after a request was offered
  a_ready_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(in_ready_i) |-> $past(in_valid_i))
    else $error("input ready dropped without a request");

endmodule

bind epipolar_line_normalize eln_checker u_eln_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (point_i.valid),
  .in_ready_i   (point_i.ready),
  .out_valid_i  (line_o.valid),
  .out_ready_i  (line_o.ready),
  .line_a_i     (line_o.line_a),
  .line_b_i     (line_o.line_b),
  .line_c_i     (line_o.line_c),
  .norm_error_i (line_o.norm_error)
);

// ===== sim/epipolar_line_normalize_tb.sv =====
// Self-checking testbench of the epipolar line normalizer: random and directed points.
module epipolar_line_normalize_tb;
  import eln_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;  // no register behind this index
  localparam int PHASE_ITEMS = 95;
  localparam int DRAIN_CYCLES = 3 * PIPE_DEPTH;

  typedef struct packed {
    logic signed [LA_W-1:0] a;
    logic signed [LA_W-1:0] b;
    logic signed [LC_W-1:0] c;
    logic                   err;
  } line_t;

  // Predicts each line from the matrix and holds the lines still to come
  class line_board;
    logic [ROW_W-1:0] rows [3];
    line_t            due_lines [$];
    int               errors;

    function new();
      rows[0] = '0;
      rows[1] = '0;
      rows[2] = '0;
      errors = 0;
    endfunction

    function void write_row(logic [CFG_IDX_W-1:0] idx, logic [ROW_W-1:0] data);
      if (idx == CFG_ROW0) rows[0] = data;
      else if (idx == CFG_ROW1) rows[1] = data;
      else if (idx == CFG_ROW2) rows[2] = data;
    endfunction

    // Exact sum of the three coefficient products of one row
    function longint row_dot(logic [ROW_W-1:0] row, logic signed [PT_W-1:0] x,
                             logic signed [PT_W-1:0] y, logic signed [PT_W-1:0] w);
      logic signed [COEF_W-1:0] k0, k1, k2;
      k0 = row[COEF_W-1:0];
      k1 = row[2*COEF_W-1:COEF_W];
      k2 = row[3*COEF_W-1:2*COEF_W];
      return longint'(k0) * longint'(x) + longint'(k1) * longint'(y)
           + longint'(k2) * longint'(w);
    endfunction

    function longint unsigned int_root(longint unsigned v);
      longint unsigned r, bitw;
      r = 0;
      bitw = 64'd1 << 62;
      while (bitw > v) bitw >>= 2;
      while (bitw != 0) begin
        if (v >= r + bitw) begin
          v = v - (r + bitw);
          r = (r >> 1) + bitw;
        end else begin
          r >>= 1;
        end
        bitw >>= 2;
      end
      return r;
    endfunction

    // Round |v| * 2^sh / n to nearest, apply the sign, clamp to a w-bit field
    function longint unsigned quotient_field(longint v, int sh, longint unsigned n, int w);
      bit neg;
      longint unsigned num, q, r, mag, lim;
      int k;
      neg = v < 0;
      num = neg ? longint'(-v) : v;
      k = sh + 1;
      if (k < 0) begin
        q = num / (n << 1);
      end else begin
        q = num / n;
        r = num % n;
        while (k > 0 && q < (64'd1 << 40)) begin
          q <<= 1;
          r <<= 1;
          if (r >= n) begin
            r -= n;
            q++;
          end
          k--;
        end
      end
      mag = (q + 1) >> 1;
      lim = 64'd1 << (w - 1);
      if (neg) begin
        if (mag > lim) mag = lim;
        return (64'd0 - mag) & ((64'd1 << w) - 1);
      end
      if (mag > lim - 1) mag = lim - 1;
      return mag;
    endfunction

    function void note_point(logic signed [PT_W-1:0] x, logic signed [PT_W-1:0] y,
                             logic signed [PT_W-1:0] w);
      longint a, b, c;
      longint unsigned ua, ub, m, na, nb, n;
      int h, e;
      line_t l;
      a = row_dot(rows[0], x, y, w);
      b = row_dot(rows[1], x, y, w);
      c = row_dot(rows[2], x, y, w);
      ua = a < 0 ? longint'(-a) : a;
      ub = b < 0 ? longint'(-b) : b;
      m = ua > ub ? ua : ub;
      l = '0;
      if (m == 0) begin
        l.err = 1'b1;
      end else begin
        h = 63;
        while (m[h] == 1'b0) h--;
        e = 30 - h;
        if (e >= 0) begin
          na = ua << e;
          nb = ub << e;
        end else begin
          na = ua >> (-e);
          nb = ub >> (-e);
        end
        n = int_root(na * na + nb * nb);
        l.a = LA_W'(quotient_field(a, e + 15, n, LA_W));
        l.b = LA_W'(quotient_field(b, e + 15, n, LA_W));
        l.c = LC_W'(quotient_field(c, e + 8, n, LC_W));
      end
      due_lines.push_back(l);
    endfunction

    function void check_line(line_t got);
      line_t want;
      if (due_lines.size() == 0) begin
        $error("line request with no point outstanding");
        errors++;
        return;
      end
      want = due_lines.pop_front();
      if (got.a !== want.a) begin
        $error("line_a expected %0d got %0d", want.a, got.a);
        errors++;
      end
      if (got.b !== want.b) begin
        $error("line_b expected %0d got %0d", want.b, got.b);
        errors++;
      end
      if (got.c !== want.c) begin
        $error("line_c expected %0d got %0d", want.c, got.c);
        errors++;
      end
      if (got.err !== want.err) begin
        $error("norm_error expected %0d got %0d", want.err, got.err);
        errors++;
      end
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = CFG_ROW0;
  logic [ROW_W-1:0]     cfg_data_i = '0;
  int                   send_idle_pct = 0;
  int                   recv_stall_pct = 0;
  line_board            board = new();

  eln_point_if point_bus ();
  eln_line_if  line_bus ();

  epipolar_line_normalize uut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .point_i   (point_bus.sink),
    .line_o    (line_bus.source)
  );

  always #4 clk_i = ~clk_i;

  initial begin
    point_bus.valid   = 1'b0;
    point_bus.point_x = '0;
    point_bus.point_y = '0;
    point_bus.point_w = '0;
    line_bus.ready    = 1'b1;
  end

  // Stall the line channel at the current rate
  initial begin
    forever begin
      @(negedge clk_i);
      line_bus.ready = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Check every accepted line request
  initial begin
    forever begin
      @(posedge clk_i);
      if (rst_ni && line_bus.valid && line_bus.ready) begin
        board.check_line({line_bus.line_a, line_bus.line_b, line_bus.line_c,
                          line_bus.norm_error});
      end
    end
  end

  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic logic [ROW_W-1:0] pack_row(logic [COEF_W-1:0] k0,
                                                logic [COEF_W-1:0] k1,
                                                logic [COEF_W-1:0] k2);
    return {k2, k1, k0};
  endfunction

  // Mix of full-range, small and extreme coefficients
  function automatic logic [COEF_W-1:0] rand_coef();
    case ($urandom_range(5))
      0: return {1'b1, {(COEF_W-1){1'b0}}};
      1: return {1'b0, {(COEF_W-1){1'b1}}};
      2: return COEF_W'($signed($urandom_range(64)) - 32);
      3: return '0;
      default: return COEF_W'($urandom);
    endcase
  endfunction

  function automatic logic [PT_W-1:0] rand_coord();
    case ($urandom_range(6))
      0: return {1'b1, {(PT_W-1){1'b0}}};
      1: return {1'b0, {(PT_W-1){1'b1}}};
      2: return PT_W'(256);
      3: return PT_W'($signed($urandom_range(2048)) - 1024);
      default: return PT_W'($urandom);
    endcase
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [ROW_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = data;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    board.write_row(idx, data);
  endtask

  // Wait until every line has come back and the pipeline is empty
  task automatic drain();
    while (board.due_lines.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic load_matrix(logic [ROW_W-1:0] r0, logic [ROW_W-1:0] r1,
                             logic [ROW_W-1:0] r2);
    drain();
    write_reg(CFG_ROW0, r0);
    write_reg(CFG_ROW1, r1);
    write_reg(CFG_ROW2, r2);
  endtask

  task automatic send_point(logic [PT_W-1:0] x, logic [PT_W-1:0] y, logic [PT_W-1:0] w);
    while ($urandom_range(99) < send_idle_pct) begin
      point_bus.valid = 1'b0;
      @(negedge clk_i);
    end
    point_bus.valid   = 1'b1;
    point_bus.point_x = x;
    point_bus.point_y = y;
    point_bus.point_w = w;
    do @(posedge clk_i); while (!point_bus.ready);
    board.note_point(x, y, w);
    @(negedge clk_i);
    point_bus.valid = 1'b0;
  endtask

  initial begin
    logic [PT_W-1:0] pmax, pmin;
    logic [COEF_W-1:0] kmax, kmin, one;
    pmax = {1'b0, {(PT_W-1){1'b1}}};
    pmin = {1'b1, {(PT_W-1){1'b0}}};
    kmax = {1'b0, {(COEF_W-1){1'b1}}};
    kmin = {1'b1, {(COEF_W-1){1'b0}}};
    one  = COEF_W'(1 << 18);

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Zero matrix after reset: every line is a norm error
    send_point(pmax, pmin, PT_W'(256));
    send_point('0, '0, '0);

    // Identity matrix: extremes of the point fields and the zero-norm case
    load_matrix(pack_row(one, '0, '0), pack_row('0, one, '0), pack_row('0, '0, one));
    write_reg(CFG_UNUSED, '1);
    send_point(pmax, pmax, pmax);
    send_point(pmin, pmin, pmin);
    send_point(pmax, pmin, pmax);
    send_point('0, '0, pmax);
    send_point('0, '0, '0);
    send_point(PT_W'(256), '0, PT_W'(256));
    send_point('0, PT_W'(1), pmin);
    send_point(PT_W'(1), PT_W'(1), pmax);
    send_point('1, '0, '0);

    // Extreme coefficients: largest sums, saturation of line_c
    load_matrix(pack_row(kmax, kmax, kmax), pack_row(kmin, kmin, kmin),
                pack_row(kmin, kmax, kmin));
    send_point(pmax, pmax, pmax);
    send_point(pmin, pmin, pmin);
    send_point(pmin, pmax, pmin);
    load_matrix(pack_row(COEF_W'(1), '0, '0), '0, pack_row(kmax, kmax, kmax));
    send_point(PT_W'(1), pmax, pmax);
    send_point(pmin, pmin, pmin);
    send_point('0, pmax, pmax);

    // Random phases across the idling modes and matrix settings
    for (int ph = 0; ph < 8; ph++) begin
      load_matrix(pack_row(rand_coef(), rand_coef(), rand_coef()),
                  pack_row(rand_coef(), rand_coef(), rand_coef()),
                  ROW_W'({$urandom, $urandom}));
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 58; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 58; end
        default: begin send_idle_pct = 15; recv_stall_pct = 15; end
      endcase
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        send_point(rand_coord(), rand_coord(), rand_coord());
      end
    end

    send_idle_pct = 0;
    drain();
    if (board.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
